[design/bmm_pkg.sv]
// ---------------------------------------------------------------------------
// bmm_pkg: shared types and constants for the banked memory map
// Word layouts on both channels, the internal command that passes from the
// decode side to the execution side, region and status codes, and the
// register indexes of the configuration port.
// ---------------------------------------------------------------------------
package bmm_pkg;

   // Request word, one byte access
   typedef struct packed {
      logic        req_type;         // 0 read, 1 write
      logic [15:0] address;
      logic [7:0]  bank_number;
      logic        use_current_bank;
      logic [7:0]  write_data;
   } bmm_req_type;

   // Response word
   typedef struct packed {
      logic [7:0] data_out;
      logic [1:0] status;
   } bmm_rsp_type;

   // Bank configuration registers
   typedef struct packed {
      logic [3:0] rom_count;
      logic [1:0] video_count;
      logic [2:0] ext_count;
      logic [3:0] work_count;
      logic [2:0] rom_current;
      logic [1:0] ext_current;
   } bmm_cfg_type;

   // Region codes
   localparam logic [3:0] RG_ROM    = 4'd0;
   localparam logic [3:0] RG_VIDEO  = 4'd1;
   localparam logic [3:0] RG_EXT    = 4'd2;
   localparam logic [3:0] RG_WORK   = 4'd3;
   localparam logic [3:0] RG_SPRITE = 4'd4;
   localparam logic [3:0] RG_NONE   = 4'd5;   // forbidden area
   localparam logic [3:0] RG_IO     = 4'd6;
   localparam logic [3:0] RG_HIGH   = 4'd7;
   localparam logic [3:0] RG_IRQ    = 4'd8;

   // Decoded command held in the queue
   typedef struct packed {
      logic [3:0]  region;
      logic        wr;
      logic [7:0]  wdata;
      logic [15:0] addr;
      logic [7:0]  bank;
      logic        io_bank;   // bank comes from an IO select byte
      logic        check;     // bank must be checked against its count
      logic        echo;      // access through the echo window
   } bmm_cmd_type;

   // Response status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BAD    = 2'd1;
   localparam logic [1:0] ST_ECHO   = 2'd2;
   localparam logic [1:0] ST_FORBID = 2'd3;

   // Region boundaries (last address of each region)
   localparam logic [15:0] END_ROM0   = 16'h3FFF;
   localparam logic [15:0] END_ROMX   = 16'h7FFF;
   localparam logic [15:0] END_VIDEO  = 16'h9FFF;
   localparam logic [15:0] END_EXT    = 16'hBFFF;
   localparam logic [15:0] END_WORK0  = 16'hCFFF;
   localparam logic [15:0] END_WORKX  = 16'hDFFF;
   localparam logic [15:0] END_ECHO   = 16'hFDFF;
   localparam logic [15:0] END_SPRITE = 16'hFE9F;
   localparam logic [15:0] END_FORBID = 16'hFEFF;
   localparam logic [15:0] END_IO     = 16'hFF7F;
   localparam logic [15:0] END_HIGH   = 16'hFFFE;

   // IO bytes that hold the video and work bank selects
   localparam logic [6:0] IO_VIDEO_SEL = 7'h4F;
   localparam logic [6:0] IO_WORK_SEL  = 7'h70;

   // Configuration port
   localparam int CSR_IW = 3;
   localparam int CSR_DW = 4;
   localparam logic [CSR_IW-1:0] CSR_ROM_COUNT   = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_VIDEO_COUNT = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_EXT_COUNT   = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_WORK_COUNT  = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_ROM_CUR     = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_EXT_CUR     = 3'd5;

   // Command queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PW    = 1;
   localparam int QUEUE_CW    = 2;

   // Small stores
   localparam int SPRITE_DEPTH = 160;
   localparam int IO_DEPTH     = 128;
   localparam int HIGH_DEPTH   = 127;

endpackage

[design/banked_memory_map_top.sv]
// ---------------------------------------------------------------------------
// banked_memory_map_top: banked memory map decoder
// Decodes byte accesses to a 16-bit banked address space and returns the
// byte read, or the old byte a write replaced, together with a status.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Word
//   req_     in         req_valid/req_stall  bmm_req_type (one byte access)
//   rsp_     out        rsp_valid/rsp_stall  bmm_rsp_type (byte and status)
//   csr_     in         csr_valid/csr_ready  csr_index, csr_data
//
// Each word passes through two states of the execution side: the idle state
// issues the registered read of the addressed store, and the execution state
// does the write-back and registers the response, waiting while a held
// response is stalled. With read-then-write on a single store port, a word
// is issued only once the last one has finished; a word passes through the
// queue entry, the store's read register and the response register.
// After reset the stores are cleared at one entry per cycle, the clear
// counter running over the deepest store (ROM_BANKS * 16384 with the
// defaults); req_stall stays high during that pass. A held response does not
// block the decode side: the queue keeps taking words until it is full.
module banked_memory_map_top
   import bmm_pkg::*;
#(
   parameter int ROM_BANKS   = 8,
   parameter int VIDEO_BANKS = 2,
   parameter int EXT_BANKS   = 4,
   parameter int WORK_BANKS  = 8
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bmm_req_type       req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bmm_rsp_type       rsp_word,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_data
);

   bmm_cfg_type cfg_ff, cfg_in;
   bmm_cmd_type dec_cmd;
   bmm_cmd_type q_head;
   logic        q_full;
   logic        q_empty;
   logic        q_pop;
   logic        clearing;
   logic        req_accept;

   // The register file is always writable; the user must change the bank selects
   // only while no word is in flight, as the block itself does not enforce it.
   assign csr_ready  = 1'b1;
   assign req_stall  = q_full || clearing;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROM_COUNT:   cfg_in.rom_count   = csr_data[3:0];
            CSR_VIDEO_COUNT: cfg_in.video_count = csr_data[1:0];
            CSR_EXT_COUNT:   cfg_in.ext_count   = csr_data[2:0];
            CSR_WORK_COUNT:  cfg_in.work_count  = csr_data[3:0];
            CSR_ROM_CUR:     cfg_in.rom_current = csr_data[2:0];
            CSR_EXT_CUR:     cfg_in.ext_current = csr_data[1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // One bank of each kind present after reset, bank zero selected.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rom_count   <= 4'd1;
         cfg_ff.video_count <= 2'd1;
         cfg_ff.ext_count   <= 3'd1;
         cfg_ff.work_count  <= 4'd1;
         cfg_ff.rom_current <= 3'd0;
         cfg_ff.ext_current <= 2'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Decode side: region, bank and checks for the incoming word.
   bmm_front u_front (
      .req (req_word),
      .cfg (cfg_ff),
      .cmd (dec_cmd)
   );

   // Decoded commands wait here while the execution side is busy.
   bmm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_accept),
      .push_cmd (dec_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   // Execution side: stores, IO bank selects and the response register.
   bmm_back #(
      .ROM_BANKS   (ROM_BANKS),
      .VIDEO_BANKS (VIDEO_BANKS),
      .EXT_BANKS   (EXT_BANKS),
      .WORK_BANKS  (WORK_BANKS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (q_head),
      .empty      (q_empty),
      .pop        (q_pop),
      .busy_clear (clearing),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

endmodule

[design/bmm_front.sv]
// ---------------------------------------------------------------------------
// bmm_front: address decode
// Classifies a request word by region, resolves the bank where it is known
// from the select registers and builds the command for the execution side.
// ---------------------------------------------------------------------------
module bmm_front
   import bmm_pkg::*;
(
   input  bmm_req_type req,
   input  bmm_cfg_type cfg,
   output bmm_cmd_type cmd
);

   logic [15:0] a;

   assign a = req.address;

   always_comb begin
      cmd         = '0;
      cmd.wr      = req.req_type;
      cmd.wdata   = req.write_data;
      cmd.addr    = a;
      priority if (a <= END_ROM0) begin
         cmd.region = RG_ROM;
      end else if (a <= END_ROMX) begin
         cmd.region = RG_ROM;
         cmd.check  = 1'b1;
         cmd.bank   = req.use_current_bank ? {5'd0, cfg.rom_current} : req.bank_number;
      end else if (a <= END_VIDEO) begin
         cmd.region  = RG_VIDEO;
         cmd.check   = 1'b1;
         cmd.bank    = req.bank_number;
         cmd.io_bank = req.use_current_bank;
      end else if (a <= END_EXT) begin
         cmd.region = RG_EXT;
         cmd.check  = 1'b1;
         cmd.bank   = req.use_current_bank ? {6'd0, cfg.ext_current} : req.bank_number;
      end else if (a <= END_WORK0) begin
         cmd.region = RG_WORK;
      end else if (a <= END_ECHO) begin
         cmd.region  = RG_WORK;
         cmd.check   = 1'b1;
         cmd.bank    = req.bank_number;
         cmd.io_bank = req.use_current_bank;
         cmd.echo    = (a > END_WORKX);
      end else if (a <= END_SPRITE) begin
         cmd.region = RG_SPRITE;
      end else if (a <= END_FORBID) begin
         cmd.region = RG_NONE;
      end else if (a <= END_IO) begin
         cmd.region = RG_IO;
      end else if (a <= END_HIGH) begin
         cmd.region = RG_HIGH;
      end else begin
         cmd.region = RG_IRQ;
      end
   end

endmodule

[design/bmm_queue.sv]
// ---------------------------------------------------------------------------
// bmm_queue: command queue
// A short first-in first-out queue of decoded commands between the decode
// side and the execution side.
// ---------------------------------------------------------------------------
module bmm_queue
   import bmm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  bmm_cmd_type push_cmd,
   output logic        full,
   input  logic        pop,
   output bmm_cmd_type head,
   output logic        empty
);

   bmm_cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]       count_ff, count_in;

   assign full  = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CW'(push) - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[design/bmm_back.sv]
// ---------------------------------------------------------------------------
// bmm_back: store access and response
// Holds every store, clears them after reset, and carries out one command
// at a time as a registered read followed by the write-back and response.
// ---------------------------------------------------------------------------
module bmm_back
   import bmm_pkg::*;
#(
   parameter int ROM_BANKS   = 8,
   parameter int VIDEO_BANKS = 2,
   parameter int EXT_BANKS   = 4,
   parameter int WORK_BANKS  = 8
)(
   input  logic        clock,
   input  logic        reset,
   input  bmm_cfg_type cfg,
   input  bmm_cmd_type head,
   input  logic        empty,
   output logic        pop,
   output logic        busy_clear,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output bmm_rsp_type rsp_word
);

   localparam int ROM_DEPTH   = ROM_BANKS * 16384;
   localparam int VIDEO_DEPTH = VIDEO_BANKS * 8192;
   localparam int EXT_DEPTH   = EXT_BANKS * 8192;
   localparam int WORK_DEPTH  = WORK_BANKS * 4096;
   localparam int ROM_AW      = $clog2(ROM_DEPTH);
   localparam int VIDEO_AW    = $clog2(VIDEO_DEPTH);
   localparam int EXT_AW      = $clog2(EXT_DEPTH);
   localparam int WORK_AW     = $clog2(WORK_DEPTH);
   localparam int ROM_BW      = (ROM_BANKS > 1) ? $clog2(ROM_BANKS) : 1;
   localparam int VIDEO_BW    = (VIDEO_BANKS > 1) ? $clog2(VIDEO_BANKS) : 1;
   localparam int EXT_BW      = (EXT_BANKS > 1) ? $clog2(EXT_BANKS) : 1;
   localparam int WORK_BW     = (WORK_BANKS > 1) ? $clog2(WORK_BANKS) : 1;
   localparam int MAX_A       = (ROM_DEPTH > VIDEO_DEPTH) ? ROM_DEPTH : VIDEO_DEPTH;
   localparam int MAX_B       = (EXT_DEPTH > WORK_DEPTH) ? EXT_DEPTH : WORK_DEPTH;
   localparam int CLR_DEPTH   = (MAX_A > MAX_B) ? MAX_A : MAX_B;
   localparam int CLW         = $clog2(CLR_DEPTH);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;

   function automatic logic [ROM_AW-1:0] rom_index(input logic [15:0] ad,
                                                   input logic [7:0] bk);
      logic [15:0]          bk16;
      logic [ROM_BW+13:0]   full;
      bk16 = {8'd0, bk};
      full = {bk16[ROM_BW-1:0], ad[13:0]};
      return full[ROM_AW-1:0];
   endfunction

   function automatic logic [VIDEO_AW-1:0] video_index(input logic [15:0] ad,
                                                       input logic [7:0] bk);
      logic [15:0]          bk16;
      logic [VIDEO_BW+12:0] full;
      bk16 = {8'd0, bk};
      full = {bk16[VIDEO_BW-1:0], ad[12:0]};
      return full[VIDEO_AW-1:0];
   endfunction

   function automatic logic [EXT_AW-1:0] ext_index(input logic [15:0] ad,
                                                   input logic [7:0] bk);
      logic [15:0]          bk16;
      logic [EXT_BW+12:0]   full;
      bk16 = {8'd0, bk};
      full = {bk16[EXT_BW-1:0], ad[12:0]};
      return full[EXT_AW-1:0];
   endfunction

   // Address bit 12 picks the banked half; the echo window keeps that bit.
   function automatic logic [WORK_AW-1:0] work_index(input logic [15:0] ad,
                                                     input logic [7:0] bk);
      logic [15:0]          bk16;
      logic [WORK_BW+11:0]  full;
      bk16 = ad[12] ? {8'd0, bk} : 16'd0;
      full = {bk16[WORK_BW-1:0], ad[11:0]};
      return full[WORK_AW-1:0];
   endfunction

   // Stores
   logic [7:0] rom_mem    [ROM_DEPTH];
   logic [7:0] video_mem  [VIDEO_DEPTH];
   logic [7:0] ext_mem    [EXT_DEPTH];
   logic [7:0] work_mem   [WORK_DEPTH];
   logic [7:0] sprite_mem [SPRITE_DEPTH];
   logic [7:0] io_mem     [IO_DEPTH];
   logic [7:0] high_mem   [HIGH_DEPTH];

   logic [7:0] rom_rd_ff, video_rd_ff, ext_rd_ff, work_rd_ff;
   logic [7:0] sprite_rd_ff, io_rd_ff, high_rd_ff;
   logic [7:0] irq_ff;
   logic [7:0] sel_video_ff, sel_work_ff;

   logic [1:0]     state_ff, state_in;
   logic [CLW-1:0] clr_ff, clr_in;
   logic           clr_last;

   // Command in execution
   logic [3:0]  x_region_ff;
   logic        x_wr_ff;
   logic [7:0]  x_wdata_ff;
   logic [15:0] x_addr_ff;
   logic [7:0]  x_bank_ff;
   logic [1:0]  x_status_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   bmm_rsp_type rsp_word_ff, rsp_word_in;

   // Issue side
   logic [7:0]  i_bank;
   logic        i_ok;
   logic [1:0]  i_status;
   logic        issue;

   // Completion side
   logic        clearing;
   logic        done;
   logic        x_store;
   logic [7:0]  x_data;
   logic [7:0]  wd;

   assign clearing   = (state_ff == S_CLEAR);
   assign busy_clear = clearing;
   assign issue      = (state_ff == S_IDLE) && !empty;
   assign pop        = issue;
   assign done       = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign x_store    = done && x_wr_ff && (x_status_ff != ST_BAD);
   assign wd         = clearing ? 8'h00 : x_wdata_ff;
   assign clr_last   = (clr_ff == CLW'(CLR_DEPTH - 1));
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;

   // Bank resolution and check for the command at the head of the queue
   always_comb begin
      i_bank = head.bank;
      if (head.io_bank) begin
         i_bank = (head.region == RG_VIDEO) ? sel_video_ff : sel_work_ff;
      end
      i_ok = 1'b1;
      if (head.check) begin
         unique case (head.region)
            RG_ROM: begin
               i_ok = (32'(i_bank) < 32'(cfg.rom_count)) && (32'(i_bank) < ROM_BANKS);
            end
            RG_VIDEO: begin
               i_ok = (32'(i_bank) < 32'(cfg.video_count)) && (32'(i_bank) < VIDEO_BANKS);
            end
            RG_EXT: begin
               i_ok = (32'(i_bank) < 32'(cfg.ext_count)) && (32'(i_bank) < EXT_BANKS);
            end
            RG_WORK: begin
               i_ok = (32'(i_bank) < 32'(cfg.work_count)) && (32'(i_bank) < WORK_BANKS);
            end
            default: begin
               i_ok = 1'b1;
            end
         endcase
      end
      priority if (head.region == RG_NONE) begin
         i_status = ST_FORBID;
      end else if (!i_ok) begin
         i_status = ST_BAD;
      end else if (head.echo) begin
         i_status = ST_ECHO;
      end else begin
         i_status = ST_OK;
      end
   end

   // Data of the finished access
   always_comb begin
      unique case (x_region_ff)
         RG_ROM:    x_data = rom_rd_ff;
         RG_VIDEO:  x_data = video_rd_ff;
         RG_EXT:    x_data = ext_rd_ff;
         RG_WORK:   x_data = work_rd_ff;
         RG_SPRITE: x_data = sprite_rd_ff;
         RG_NONE:   x_data = {x_addr_ff[7:4], x_addr_ff[7:4]};
         RG_IO:     x_data = io_rd_ff;
         RG_HIGH:   x_data = high_rd_ff;
         RG_IRQ:    x_data = irq_ff;
         default:   x_data = 8'h00;
      endcase
      if (x_status_ff == ST_BAD) begin
         x_data = 8'h00;
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (issue) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = done ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_word_in  = rsp_word_ff;
      if (done) begin
         rsp_word_in.data_out = x_data;
         rsp_word_in.status   = x_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         irq_ff       <= 8'h00;
         sel_video_ff <= 8'h00;
         sel_work_ff  <= 8'h00;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (x_store && (x_region_ff == RG_IRQ)) begin
            irq_ff <= x_wdata_ff;
         end
         if (x_store && (x_region_ff == RG_IO) && (x_addr_ff[6:0] == IO_VIDEO_SEL)) begin
            sel_video_ff <= x_wdata_ff;
         end
         if (x_store && (x_region_ff == RG_IO) && (x_addr_ff[6:0] == IO_WORK_SEL)) begin
            sel_work_ff <= x_wdata_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      if (issue) begin
         x_region_ff <= head.region;
         x_wr_ff     <= head.wr;
         x_wdata_ff  <= head.wdata;
         x_addr_ff   <= head.addr;
         x_bank_ff   <= i_bank;
         x_status_ff <= i_status;
      end
   end

   // ROM store
   always_ff @(posedge clock) begin
      if (clearing && (32'(clr_ff) < ROM_DEPTH)) begin
         rom_mem[clr_ff[ROM_AW-1:0]] <= wd;
      end else if (x_store && (x_region_ff == RG_ROM)) begin
         rom_mem[rom_index(x_addr_ff, x_bank_ff)] <= wd;
      end
      if (issue && (head.region == RG_ROM)) begin
         rom_rd_ff <= rom_mem[rom_index(head.addr, i_bank)];
      end
   end

   // Video RAM store
   always_ff @(posedge clock) begin
      if (clearing && (32'(clr_ff) < VIDEO_DEPTH)) begin
         video_mem[clr_ff[VIDEO_AW-1:0]] <= wd;
      end else if (x_store && (x_region_ff == RG_VIDEO)) begin
         video_mem[video_index(x_addr_ff, x_bank_ff)] <= wd;
      end
      if (issue && (head.region == RG_VIDEO)) begin
         video_rd_ff <= video_mem[video_index(head.addr, i_bank)];
      end
   end

   // External RAM store
   always_ff @(posedge clock) begin
      if (clearing && (32'(clr_ff) < EXT_DEPTH)) begin
         ext_mem[clr_ff[EXT_AW-1:0]] <= wd;
      end else if (x_store && (x_region_ff == RG_EXT)) begin
         ext_mem[ext_index(x_addr_ff, x_bank_ff)] <= wd;
      end
      if (issue && (head.region == RG_EXT)) begin
         ext_rd_ff <= ext_mem[ext_index(head.addr, i_bank)];
      end
   end

   // Work RAM store
   always_ff @(posedge clock) begin
      if (clearing && (32'(clr_ff) < WORK_DEPTH)) begin
         work_mem[clr_ff[WORK_AW-1:0]] <= wd;
      end else if (x_store && (x_region_ff == RG_WORK)) begin
         work_mem[work_index(x_addr_ff, x_bank_ff)] <= wd;
      end
      if (issue && (head.region == RG_WORK)) begin
         work_rd_ff <= work_mem[work_index(head.addr, i_bank)];
      end
   end

   // Sprite store
   always_ff @(posedge clock) begin
      if (clearing && (32'(clr_ff) < SPRITE_DEPTH)) begin
         sprite_mem[clr_ff[7:0]] <= wd;
      end else if (x_store && (x_region_ff == RG_SPRITE)) begin
         sprite_mem[x_addr_ff[7:0]] <= wd;
      end
      if (issue && (head.region == RG_SPRITE)) begin
         sprite_rd_ff <= sprite_mem[head.addr[7:0]];
      end
   end

   // IO bytes
   always_ff @(posedge clock) begin
      if (clearing && (32'(clr_ff) < IO_DEPTH)) begin
         io_mem[clr_ff[6:0]] <= wd;
      end else if (x_store && (x_region_ff == RG_IO)) begin
         io_mem[x_addr_ff[6:0]] <= wd;
      end
      if (issue && (head.region == RG_IO)) begin
         io_rd_ff <= io_mem[head.addr[6:0]];
      end
   end

   // High RAM
   always_ff @(posedge clock) begin
      if (clearing && (32'(clr_ff) < HIGH_DEPTH)) begin
         high_mem[clr_ff[6:0]] <= wd;
      end else if (x_store && (x_region_ff == RG_HIGH)) begin
         high_mem[x_addr_ff[6:0]] <= wd;
      end
      if (issue && (head.region == RG_HIGH)) begin
         high_rd_ff <= high_mem[head.addr[6:0]];
      end
   end

endmodule

[design/bmm_checker.sv]
// ---------------------------------------------------------------------------
// bmm_checker: port checks for the banked memory map
// Watches the response channel for a held word and for the fixed forms of
// the error and forbidden-area responses.
// ---------------------------------------------------------------------------
module bmm_checker
   import bmm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input bmm_rsp_type rsp_word
);

   // A stalled response word stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   // An invalid bank never returns data.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status == ST_BAD) |-> (rsp_word.data_out == 8'h00))
      else $error("invalid bank response carries data");

   // The forbidden area answers with its address nibble doubled, A to F.
   a_forbid_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status == ST_FORBID) |->
         (rsp_word.data_out[7:4] == rsp_word.data_out[3:0]) &&
         (rsp_word.data_out[7:4] >= 4'hA))
      else $error("forbidden area response malformed");

endmodule

bind banked_memory_map_top bmm_checker u_bmm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

[sim/tb_banked_memory_map_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_banked_memory_map_top: self-checking bench for the banked memory map
// Drives byte accesses into the block with random gaps and back-pressure. It
// keeps its own image of every store and of the bank registers, works out the
// reply to each accepted word, and compares the replies in order.
// ---------------------------------------------------------------------------
module tb_banked_memory_map_top
   import bmm_pkg::*;
();

   // Store sizes match the parameters that the block is built with below.
   localparam int ROM_BANKS    = 8;
   localparam int VIDEO_BANKS  = 2;
   localparam int EXT_BANKS    = 4;
   localparam int WORK_BANKS   = 8;
   localparam int ROM_PAGE     = 16384;
   localparam int VIDEO_PAGE   = 8192;
   localparam int EXT_PAGE     = 8192;
   localparam int WORK_PAGE    = 4096;
   // A word is written back in the same cycle that registers its reply, so
   // a few idle cycles after the last reply leave the block truly quiet.
   localparam int SETTLE_CYCLES = 8;
   localparam int ITEMS_PER_PHASE = 240;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   bmm_req_type req_word;
   logic        rsp_valid;
   logic        rsp_stall;
   bmm_rsp_type rsp_word;
   logic        csr_valid;
   logic        csr_ready;
   logic [CSR_IW-1:0] csr_index;
   logic [CSR_DW-1:0] csr_data;

   // Image of the block's state, updated as each word is accepted.
   bit [7:0]    rom_image    [ROM_BANKS*ROM_PAGE];
   bit [7:0]    video_image  [VIDEO_BANKS*VIDEO_PAGE];
   bit [7:0]    ext_image    [EXT_BANKS*EXT_PAGE];
   bit [7:0]    work_image   [WORK_BANKS*WORK_PAGE];
   bit [7:0]    sprite_image [SPRITE_DEPTH];
   bit [7:0]    io_image     [IO_DEPTH];
   bit [7:0]    high_image   [HIGH_DEPTH];
   bit [7:0]    irq_image;
   bmm_cfg_type bank_cfg;

   bmm_rsp_type    pending_replies[$];
   logic [15:0]    recent_addresses[$];
   int             mismatch_count = 0;
   bit             sender_quiet   = 1'b0;
   bit             receiver_quiet = 1'b0;
   int             rsp_hold_cycles = 0;

   banked_memory_map_top #(
      .ROM_BANKS   (ROM_BANKS),
      .VIDEO_BANKS (VIDEO_BANKS),
      .EXT_BANKS   (EXT_BANKS),
      .WORK_BANKS  (WORK_BANKS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 20 ns period; the first rising edge falls at 10 ns.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // A bank must lie below both its count register and the size of its store.
   function automatic bit bank_present(input int unsigned bank, input int unsigned count,
                                       input int unsigned limit);
      return bank < count && bank < limit;
   endfunction

   // Works out the reply to one access and applies its write to the image.
   // The region code picks the store touched; RG_NONE means nothing is read
   // or written, as for a bad bank or the forbidden area.
   function automatic bmm_rsp_type decode_access(input bmm_req_type w);
      bmm_rsp_type res;
      logic [3:0]  region;
      int unsigned bank;
      int unsigned idx;
      int unsigned addr;
      bit          echo;
      res    = '0;
      region = RG_NONE;
      idx    = 0;
      addr   = 32'(w.address);
      if (w.address <= END_ROM0) begin
         region = RG_ROM;
         idx    = addr;
      end else if (w.address <= END_ROMX) begin
         bank = w.use_current_bank ? 32'(bank_cfg.rom_current) : 32'(w.bank_number);
         if (bank_present(bank, 32'(bank_cfg.rom_count), ROM_BANKS)) begin
            region = RG_ROM;
            idx    = bank * ROM_PAGE + (addr - 'h4000);
         end else begin
            res.status = ST_BAD;
         end
      end else if (w.address <= END_VIDEO) begin
         // The whole select byte counts, not just its low bits.
         bank = w.use_current_bank ? 32'(io_image[IO_VIDEO_SEL]) : 32'(w.bank_number);
         if (bank_present(bank, 32'(bank_cfg.video_count), VIDEO_BANKS)) begin
            region = RG_VIDEO;
            idx    = bank * VIDEO_PAGE + (addr - 'h8000);
         end else begin
            res.status = ST_BAD;
         end
      end else if (w.address <= END_EXT) begin
         bank = w.use_current_bank ? 32'(bank_cfg.ext_current) : 32'(w.bank_number);
         if (bank_present(bank, 32'(bank_cfg.ext_count), EXT_BANKS)) begin
            region = RG_EXT;
            idx    = bank * EXT_PAGE + (addr - 'hA000);
         end else begin
            res.status = ST_BAD;
         end
      end else if (w.address <= END_WORK0) begin
         region = RG_WORK;
         idx    = addr - 'hC000;
      end else if (w.address <= END_ECHO) begin
         // The echo window is checked for its bank before it is folded down,
         // even where it lands on the fixed work bank.
         echo = w.address > END_WORKX;
         if (echo)
            addr = addr - 'h2000;
         bank = w.use_current_bank ? 32'(io_image[IO_WORK_SEL]) : 32'(w.bank_number);
         if (!bank_present(bank, 32'(bank_cfg.work_count), WORK_BANKS)) begin
            res.status = ST_BAD;
         end else begin
            region = RG_WORK;
            // Bank zero in the switched window is the fixed bank itself.
            idx = (addr <= END_WORK0) ? addr - 'hC000 : bank * WORK_PAGE + (addr - 'hD000);
            if (echo)
               res.status = ST_ECHO;
         end
      end else if (w.address <= END_SPRITE) begin
         region = RG_SPRITE;
         idx    = addr - 'hFE00;
      end else if (w.address <= END_FORBID) begin
         res.data_out = {w.address[7:4], w.address[7:4]};
         res.status   = ST_FORBID;
      end else if (w.address <= END_IO) begin
         region = RG_IO;
         idx    = addr - 'hFF00;
      end else if (w.address <= END_HIGH) begin
         region = RG_HIGH;
         idx    = addr - 'hFF80;
      end else begin
         region = RG_IRQ;
      end

      case (region)
         RG_ROM: begin
            res.data_out = rom_image[idx];
            if (w.req_type) rom_image[idx] = w.write_data;
         end
         RG_VIDEO: begin
            res.data_out = video_image[idx];
            if (w.req_type) video_image[idx] = w.write_data;
         end
         RG_EXT: begin
            res.data_out = ext_image[idx];
            if (w.req_type) ext_image[idx] = w.write_data;
         end
         RG_WORK: begin
            res.data_out = work_image[idx];
            if (w.req_type) work_image[idx] = w.write_data;
         end
         RG_SPRITE: begin
            res.data_out = sprite_image[idx];
            if (w.req_type) sprite_image[idx] = w.write_data;
         end
         RG_IO: begin
            res.data_out = io_image[idx];
            if (w.req_type) io_image[idx] = w.write_data;
         end
         RG_HIGH: begin
            res.data_out = high_image[idx];
            if (w.req_type) high_image[idx] = w.write_data;
         end
         RG_IRQ: begin
            res.data_out = irq_image;
            if (w.req_type) irq_image = w.write_data;
         end
         default: ;
      endcase
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   function automatic bmm_req_type byte_access(input bit wr, input logic [15:0] addr,
                                               input logic [7:0] bank, input bit cur,
                                               input logic [7:0] data);
      bmm_req_type w;
      w.req_type         = wr;
      w.address          = addr;
      w.bank_number      = bank;
      w.use_current_bank = cur;
      w.write_data       = data;
      return w;
   endfunction

   // Offsets bunch up at both ends of a region so that reads often meet
   // earlier writes; one in four spreads over the whole span.
   function automatic int unsigned span_offset(input int unsigned span);
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, span - 1);
         1:       return span - 1 - $urandom_range(0, 15);
         default: return $urandom_range(0, 15);
      endcase
   endfunction

   function automatic logic [15:0] fresh_address();
      case ($urandom_range(0, 12))
         0:       return 16'(span_offset('h4000));
         1:       return 16'('h4000 + span_offset('h4000));
         2:       return 16'('h8000 + span_offset('h2000));
         3:       return 16'('hA000 + span_offset('h2000));
         4:       return 16'('hC000 + span_offset('h1000));
         5, 6:    return 16'('hD000 + span_offset('h1000));
         7:       return 16'('hE000 + span_offset('h1E00));
         8:       return 16'('hFE00 + span_offset(SPRITE_DEPTH));
         9:       return 16'('hFEA0 + span_offset(96));
         10: begin
            case ($urandom_range(0, 2))
               0:       return {8'hFF, 1'b0, IO_VIDEO_SEL};
               1:       return {8'hFF, 1'b0, IO_WORK_SEL};
               default: return 16'('hFF00 + span_offset(IO_DEPTH));
            endcase
         end
         11:      return 16'('hFF80 + span_offset(HIGH_DEPTH));
         default: return 16'hFFFF;
      endcase
   endfunction

   // Random access: addresses are often taken again from a short history, and
   // banks mostly lie near the present counts so that most accesses get
   // through to a store.
   function automatic bmm_req_type random_access();
      bmm_req_type w;
      int unsigned pick;
      w.req_type         = 1'($urandom_range(0, 1));
      w.use_current_bank = 1'($urandom_range(0, 1));
      w.write_data       = 8'($urandom_range(0, 255));
      pick               = $urandom_range(0, 9);
      if (pick < 7)
         w.bank_number = 8'($urandom_range(0, 8));
      else if (pick < 9)
         w.bank_number = 8'($urandom_range(0, 3));
      else
         w.bank_number = 8'($urandom_range(0, 255));
      if (recent_addresses.size() != 0 && $urandom_range(0, 9) < 4) begin
         w.address = recent_addresses[$urandom_range(0, recent_addresses.size() - 1)];
      end else begin
         w.address = fresh_address();
         recent_addresses.push_back(w.address);
         if (recent_addresses.size() > 64)
            void'(recent_addresses.pop_front());
      end
      // Select bytes are mostly loaded with plausible bank numbers.
      if ((w.address == {8'hFF, 1'b0, IO_VIDEO_SEL} || w.address == {8'hFF, 1'b0, IO_WORK_SEL})
          && $urandom_range(0, 4) != 0)
         w.write_data = 8'($urandom_range(0, 9));
      return w;
   endfunction

   // Offers one word after a random gap and holds it until it is taken. The
   // reply is predicted at the edge that accepts the word.
   task automatic send_word(input bmm_req_type w);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 15);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      pending_replies.push_back(decode_access(w));
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_for_replies();
      while (pending_replies.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_bank_reg(input logic [CSR_IW-1:0] index,
                                 input logic [CSR_DW-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_ROM_COUNT:   bank_cfg.rom_count   = value;
         CSR_VIDEO_COUNT: bank_cfg.video_count = value[1:0];
         CSR_EXT_COUNT:   bank_cfg.ext_count   = value[2:0];
         CSR_WORK_COUNT:  bank_cfg.work_count  = value;
         CSR_ROM_CUR:     bank_cfg.rom_current = value[2:0];
         CSR_EXT_CUR:     bank_cfg.ext_current = value[1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Registers only change once the block has emptied and settled.
   task automatic set_bank_config(input int rom_n, input int video_n, input int ext_n,
                                  input int work_n, input int rom_sel, input int ext_sel);
      end_burst();
      wait_for_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_bank_reg(CSR_ROM_COUNT,   CSR_DW'(rom_n));
      write_bank_reg(CSR_VIDEO_COUNT, CSR_DW'(video_n));
      write_bank_reg(CSR_EXT_COUNT,   CSR_DW'(ext_n));
      write_bank_reg(CSR_WORK_COUNT,  CSR_DW'(work_n));
      write_bank_reg(CSR_ROM_CUR,     CSR_DW'(rom_sel));
      write_bank_reg(CSR_EXT_CUR,     CSR_DW'(ext_sel));
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Edges of every region under the reset settings: one bank of each kind,
   // both select registers at zero.
   task automatic test_region_edges();
      send_word(byte_access(1, 16'h0000, 8'h00, 0, 8'hFF));
      send_word(byte_access(0, 16'h0000, 8'hFF, 1, 8'h00));
      send_word(byte_access(1, 16'h3FFF, 8'h07, 1, 8'hA5));
      send_word(byte_access(1, 16'h4000, 8'hFF, 1, 8'h5A));
      // Bank 1 is beyond a count of one.
      send_word(byte_access(0, 16'h7FFF, 8'h01, 0, 8'h00));
      send_word(byte_access(1, 16'h8000, 8'h00, 1, 8'h11));
      send_word(byte_access(0, 16'h9FFF, 8'hFF, 0, 8'h00));
      send_word(byte_access(1, 16'hBFFF, 8'h00, 0, 8'h22));
      send_word(byte_access(1, 16'hC000, 8'h00, 0, 8'h33));
      // Switched work bank zero is the fixed bank, and so is the echo of it.
      send_word(byte_access(0, 16'hD000, 8'h00, 0, 8'h00));
      send_word(byte_access(0, 16'hE000, 8'h00, 1, 8'h00));
      send_word(byte_access(1, 16'hFDFF, 8'h00, 0, 8'h99));
      // The forbidden area answers with its address nibble and keeps nothing.
      send_word(byte_access(1, 16'hFEA5, 8'h00, 0, 8'h77));
      send_word(byte_access(0, 16'hFEFF, 8'h00, 0, 8'h00));
      send_word(byte_access(1, 16'hFE9F, 8'h00, 0, 8'h55));
      // Accesses through a video select of one are refused while only one bank is present.
      send_word(byte_access(1, {8'hFF, 1'b0, IO_VIDEO_SEL}, 8'h00, 0, 8'h01));
      send_word(byte_access(0, 16'h8000, 8'h00, 1, 8'h00));
      send_word(byte_access(1, 16'hFFFF, 8'h00, 0, 8'hC3));
      send_word(byte_access(0, 16'hFFFF, 8'h00, 0, 8'h00));
   endtask

   // Counts of zero, then counts above what the stores can hold.
   task automatic test_bank_limits();
      set_bank_config(0, 0, 0, 0, 7, 3);
      // Fixed ROM stays reachable with no banks present.
      send_word(byte_access(0, 16'h1234, 8'h00, 0, 8'h00));
      send_word(byte_access(0, 16'h4000, 8'h00, 0, 8'h00));
      send_word(byte_access(1, 16'hA000, 8'h00, 1, 8'h44));
      send_word(byte_access(0, 16'hC010, 8'h00, 0, 8'h00));
      // The echo window is refused on its bank before it is folded down.
      send_word(byte_access(0, 16'hE010, 8'h00, 0, 8'h00));

      set_bank_config(15, 3, 7, 15, 7, 3);
      send_word(byte_access(1, 16'h7FFF, 8'h00, 1, 8'h6D));
      send_word(byte_access(1, 16'h4000, 8'h08, 0, 8'h01));
      send_word(byte_access(1, 16'hBFFF, 8'h00, 1, 8'hE7));
      send_word(byte_access(1, {8'hFF, 1'b0, IO_WORK_SEL}, 8'h00, 0, 8'h08));
      send_word(byte_access(0, 16'hD000, 8'h00, 1, 8'h00));
   endtask

   // Several register settings, each followed by a run of random accesses.
   // Stretches with no idling on either side are mixed in at random.
   task automatic test_random_traffic();
      int phase;
      int k;
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_bank_config(8, 2, 4, 8, 7, 3);
            1: set_bank_config(1, 1, 1, 1, 0, 0);
            2: set_bank_config(15, 3, 7, 15, $urandom_range(0, 7), $urandom_range(0, 3));
            default: set_bank_config($urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 8),
                                     $urandom_range(1, 2), $urandom_range(1, 4),
                                     $urandom_range(1, 8), $urandom_range(0, 7),
                                     $urandom_range(0, 3));
         endcase
         for (k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (k % 40 == 0) begin
               sender_quiet   = ($urandom_range(0, 3) == 0);
               receiver_quiet = ($urandom_range(0, 3) == 0);
            end
            send_word(random_access());
         end
         sender_quiet   = 1'b0;
         receiver_quiet = 1'b0;
      end
   endtask

   // The receiver holds off for a long stretch while words keep coming, so
   // the queue fills and the input stalls; then the sender waits for every
   // reply before it starts again.
   task automatic test_backpressure();
      int k;
      set_bank_config(8, 2, 4, 8, 3, 1);
      rsp_hold_cycles = 300;
      sender_quiet    = 1'b1;
      for (k = 0; k < 40; k++)
         send_word(random_access());
      sender_quiet = 1'b0;
      end_burst();
      wait_for_replies();
      for (k = 0; k < 24; k++)
         send_word(random_access());
   endtask

   // -------------------------------------------------------------------------
   // Receiver: draws a stall for every reply, and takes a long hold-off when
   // one is asked for. Stall is left high on idle cycles as well, so gaps
   // land on every phase of the block's work.
   // -------------------------------------------------------------------------
   initial begin : reply_receiver
      int gap;
      rsp_stall = 1'b0;
      forever begin
         gap = receiver_quiet ? 0 : $urandom_range(0, 15);
         if (rsp_hold_cycles != 0) begin
            gap             = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         repeat (gap) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // -------------------------------------------------------------------------
   // Reply checker: every taken reply is matched against the oldest
   // prediction, field by field.
   // -------------------------------------------------------------------------
   task automatic note_mismatch(input string what, input bmm_rsp_type want,
                                input bmm_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: expected data %02h status %0d, got data %02h status %0d",
                  $realtime, what, want.data_out, want.status, got.data_out, got.status);
   endtask

   always @(posedge clock) begin : reply_checker
      bmm_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            note_mismatch("reply with nothing outstanding", '0, rsp_word);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_word.data_out !== want.data_out || rsp_word.status !== want.status)
               note_mismatch("reply mismatch", want, rsp_word);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      bank_cfg  = '{rom_count: 4'd1, video_count: 2'd1, ext_count: 3'd1, work_count: 4'd1,
                    rom_current: 3'd0, ext_current: 2'd0};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The block clears its stores after reset with the input stalled; the
      // first word simply waits for that pass to finish.
      test_region_edges();
      test_bank_limits();
      test_random_traffic();
      test_backpressure();

      end_burst();
      wait_for_replies();
      repeat (SETTLE_CYCLES * 4) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Overall limit: the clearing pass after reset plus the slowest run of all
   // the traffic, taken several times over.
   initial begin
      #25_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
